@@ design/wtsp_pkg.sv @@
// shared types, widths and register codes of the world-to-screen projection
// no dependencies
package wtsp_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int IN_W       = 32;
    localparam int PROD_W     = 2 * IN_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int C_W        = SUM_W - FRAC_BITS + 1;
    localparam int MAG_W      = C_W;
    localparam int Q_W        = 40;
    localparam int DIV_W      = MAG_W + Q_W;
    localparam int NDC_W      = Q_W + 2;
    localparam int V_W        = IN_W + 3;
    localparam int DIM_W      = 16;
    localparam int MUL_W      = V_W + DIM_W + 1;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int FLOOR_W    = 31;
    localparam int MIDQ_DEPTH = 4;
    localparam int MIDQ_AW    = 2;
    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_AW    = 1;
    localparam longint CLAMP_MAG = (longint'(1) << IN_W) + 2;
    localparam longint OUT_MAX   = (longint'(1) << (IN_W - 1)) - 1;
    localparam longint OUT_MIN   = -(longint'(1) << (IN_W - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X_LO = 3'd0,
        REG_ROW_X_HI = 3'd1,
        REG_ROW_Y_LO = 3'd2,
        REG_ROW_Y_HI = 3'd3,
        REG_ROW_W_LO = 3'd4,
        REG_ROW_W_HI = 3'd5,
        REG_SCREEN   = 3'd6,
        REG_FLOOR    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [IN_W-1:0] cx;
        logic signed [IN_W-1:0] cy;
        logic signed [IN_W-1:0] cz;
        logic signed [IN_W-1:0] ct;
    } t_row;

    typedef struct packed {
        t_row row_x;
        t_row row_y;
        t_row row_w;
    } t_rows;

    typedef struct packed {
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [FLOOR_W-1:0] floor_v;
    } t_view;

    typedef struct packed {
        logic signed [C_W-1:0] cx;
        logic signed [C_W-1:0] cy;
        logic signed [C_W-1:0] cw;
    } t_clip;

    typedef struct packed {
        logic            full;
        logic            empty;
        logic            push;
        logic            pop;
    } t_q_stat;

endpackage

@@ design/wtsp_front.sv @@
// front part: accepts world points and forms the x, y and w clip values
// depends on wtsp_pkg
module wtsp_front import wtsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic signed [IN_W-1:0] i_world_x,
    input  logic signed [IN_W-1:0] i_world_y,
    input  logic signed [IN_W-1:0] i_world_z,
    input  t_rows                  i_rows,
    input  logic                   i_mid_full,
    output logic                   o_clip_vld,
    output t_clip                  o_clip
);

    logic                     r_f0_vld, r_f1_vld, r_f2_vld, r_f3_vld;
    logic signed [IN_W-1:0]   r_px, r_py, r_pz;
    logic signed [PROD_W-1:0] r_prod [3][3];
    logic signed [SUM_W-1:0]  r_sum [3];
    t_clip                    r_clip;
    t_row                     w_row [3];
    logic                     w_en;

    assign w_row[0] = i_rows.row_x;
    assign w_row[1] = i_rows.row_y;
    assign w_row[2] = i_rows.row_w;

    // the whole front moves unless its last stage cannot transfer
    assign w_en = !(r_f3_vld && i_mid_full);
    assign full = !w_en;

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_vld <= 1'b0;
            r_f1_vld <= 1'b0;
            r_f2_vld <= 1'b0;
            r_f3_vld <= 1'b0;
        end else if (w_en) begin
            r_f0_vld <= push;
            r_f1_vld <= r_f0_vld;
            r_f2_vld <= r_f1_vld;
            r_f3_vld <= r_f2_vld;
        end
    end

    // point capture, products, row sums, floor and translation
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_px <= i_world_x;
            r_py <= i_world_y;
            r_pz <= i_world_z;
            for (int r = 0; r < 3; r++) begin
                r_prod[r][0] <= PROD_W'(w_row[r].cx) * PROD_W'(r_px);
                r_prod[r][1] <= PROD_W'(w_row[r].cy) * PROD_W'(r_py);
                r_prod[r][2] <= PROD_W'(w_row[r].cz) * PROD_W'(r_pz);
                r_sum[r] <= SUM_W'(r_prod[r][0]) + SUM_W'(r_prod[r][1])
                          + SUM_W'(r_prod[r][2]);
            end
            r_clip.cx <= C_W'(r_sum[0] >>> FRAC_BITS) + C_W'(w_row[0].ct);
            r_clip.cy <= C_W'(r_sum[1] >>> FRAC_BITS) + C_W'(w_row[1].ct);
            r_clip.cw <= C_W'(r_sum[2] >>> FRAC_BITS) + C_W'(w_row[2].ct);
        end
    end

    assign o_clip_vld = r_f3_vld;
    assign o_clip     = r_clip;

endmodule

@@ design/wtsp_fifo.sv @@
// short queue of clip values between the front and the back part
// depends on wtsp_pkg
module wtsp_fifo import wtsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_clip   i_data,
    input  logic    i_pop,
    output t_clip   o_data,
    output t_q_stat o_stat
);

    t_clip              r_mem [MIDQ_DEPTH];
    logic [MIDQ_AW-1:0] r_wr, r_rd;
    logic [MIDQ_AW:0]   r_cnt;
    logic               w_push, w_pop;

    assign o_stat.full  = (r_cnt == (MIDQ_AW+1)'(MIDQ_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_stat.push  = w_push;
    assign o_stat.pop   = w_pop;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= r_wr + 1'b1;
            if (w_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (MIDQ_AW+1)'(w_push) - (MIDQ_AW+1)'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr] <= i_data;
    end

    assign o_data = r_mem[r_rd];

endmodule

@@ design/wtsp_back.sv @@
// back part: depth floor, pipelined perspective divide, viewport mapping
// and result queue; depends on wtsp_pkg
module wtsp_back import wtsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_view                  i_view,
    input  t_clip                  i_clip,
    input  logic                   i_clip_empty,
    output logic                   o_clip_pop,
    output logic                   empty,
    input  logic                   pop,
    output logic signed [IN_W-1:0] o_screen_x,
    output logic signed [IN_W-1:0] o_screen_y,
    output logic                   o_saturated
);

    typedef struct packed {
        logic             vld;
        logic [DIV_W-1:0] rx;
        logic [DIV_W-1:0] ry;
        logic [Q_W-1:0]   qx;
        logic [Q_W-1:0]   qy;
        logic             satx;
        logic             saty;
        logic             negx;
        logic             negy;
        logic [MAG_W-1:0] d;
    } t_div;

    typedef struct packed {
        logic signed [IN_W-1:0] sx;
        logic signed [IN_W-1:0] sy;
        logic                   sat;
    } t_result;

    logic                    w_en;
    logic                    r_b0_vld, r_m0_vld, r_m1_vld;
    logic [MAG_W-1:0]        r_nx, r_ny, r_d;
    logic                    r_negx, r_negy;
    t_div                    r_div [Q_W+1];
    t_div                    n_div [Q_W+1];
    logic signed [V_W-1:0]   r_vx, r_vy;
    logic signed [MUL_W-1:0] r_mx, r_my;
    logic [MAG_W-1:0]        w_ax, w_ay, w_aw, w_floor;
    logic signed [MUL_W-1:0] w_shx, w_shy;
    t_result                 w_res;
    t_result                 r_q [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]      r_qwr, r_qrd;
    logic [OUTQ_AW:0]        r_qcnt;
    logic                    w_qfull, w_qpush, w_qpop;

    // signed quotient plus or minus one, held to a range that keeps saturation
    function automatic logic signed [V_W-1:0] map_v(input logic [Q_W-1:0] q,
                                                    input logic sat,
                                                    input logic neg,
                                                    input logic flip);
        logic [NDC_W-1:0]        mag;
        logic signed [NDC_W:0]   ndc;
        logic signed [NDC_W:0]   v;
        logic signed [NDC_W:0]   hi;
        mag = sat ? (NDC_W'(1) << Q_W) : NDC_W'(q);
        ndc = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        if (flip) v = (NDC_W+1)'(longint'(1) << FRAC_BITS) - ndc;
        else      v = ndc + (NDC_W+1)'(longint'(1) << FRAC_BITS);
        hi = (NDC_W+1)'(CLAMP_MAG);
        if (v > hi)       map_v = V_W'(CLAMP_MAG);
        else if (v < -hi) map_v = V_W'(-CLAMP_MAG);
        else              map_v = V_W'(v);
    endfunction

    assign w_qfull = (r_qcnt == (OUTQ_AW+1)'(OUTQ_DEPTH));
    assign w_en    = !(r_m1_vld && w_qfull);
    assign o_clip_pop = w_en && !i_clip_empty;

    // magnitudes and divisor with the depth floor
    always_comb begin
        w_ax    = i_clip.cx[C_W-1] ? MAG_W'(-i_clip.cx) : MAG_W'(i_clip.cx);
        w_ay    = i_clip.cy[C_W-1] ? MAG_W'(-i_clip.cy) : MAG_W'(i_clip.cy);
        w_aw    = i_clip.cw[C_W-1] ? MAG_W'(-i_clip.cw) : MAG_W'(i_clip.cw);
        w_floor = (i_view.floor_v == '0) ? MAG_W'(1) : MAG_W'(i_view.floor_v);
        if (w_aw < w_floor) w_aw = w_floor;
    end

    // divider stages: entry stage checks the cap, then one quotient bit each
    always_comb begin
        n_div[0]      = r_div[0];
        n_div[0].vld  = r_b0_vld;
        n_div[0].rx   = DIV_W'(r_nx) << FRAC_BITS;
        n_div[0].ry   = DIV_W'(r_ny) << FRAC_BITS;
        n_div[0].qx   = '0;
        n_div[0].qy   = '0;
        n_div[0].satx = DIV_W'(r_nx) >= (DIV_W'(r_d) << (Q_W - FRAC_BITS));
        n_div[0].saty = DIV_W'(r_ny) >= (DIV_W'(r_d) << (Q_W - FRAC_BITS));
        n_div[0].negx = r_negx;
        n_div[0].negy = r_negy;
        n_div[0].d    = r_d;
        for (int k = 1; k <= Q_W; k++) begin
            n_div[k] = r_div[k-1];
            if (r_div[k-1].rx >= (DIV_W'(r_div[k-1].d) << (Q_W - k))) begin
                n_div[k].rx = r_div[k-1].rx - (DIV_W'(r_div[k-1].d) << (Q_W - k));
                n_div[k].qx[Q_W-k] = 1'b1;
            end
            if (r_div[k-1].ry >= (DIV_W'(r_div[k-1].d) << (Q_W - k))) begin
                n_div[k].ry = r_div[k-1].ry - (DIV_W'(r_div[k-1].d) << (Q_W - k));
                n_div[k].qy[Q_W-k] = 1'b1;
            end
        end
    end

    // stage valids and payloads
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_vld <= 1'b0;
            r_m0_vld <= 1'b0;
            r_m1_vld <= 1'b0;
            for (int k = 0; k <= Q_W; k++) r_div[k].vld <= 1'b0;
        end else if (w_en) begin
            r_b0_vld <= !i_clip_empty;
            r_m0_vld <= r_div[Q_W].vld;
            r_m1_vld <= r_m0_vld;
            r_nx   <= w_ax;
            r_ny   <= w_ay;
            r_d    <= w_aw;
            r_negx <= i_clip.cx[C_W-1];
            r_negy <= i_clip.cy[C_W-1];
            for (int k = 0; k <= Q_W; k++) r_div[k] <= n_div[k];
            r_vx <= map_v(r_div[Q_W].qx, r_div[Q_W].satx, r_div[Q_W].negx, 1'b0);
            r_vy <= map_v(r_div[Q_W].qy, r_div[Q_W].saty, r_div[Q_W].negy, 1'b1);
            r_mx <= MUL_W'(r_vx) * MUL_W'($signed({1'b0, i_view.width}));
            r_my <= MUL_W'(r_vy) * MUL_W'($signed({1'b0, i_view.height}));
        end
    end

    // halve and saturate
    always_comb begin
        w_shx = r_mx >>> 1;
        w_shy = r_my >>> 1;
        w_res.sat = 1'b0;
        if (w_shx > MUL_W'(OUT_MAX)) begin
            w_res.sx = IN_W'(OUT_MAX); w_res.sat = 1'b1;
        end else if (w_shx < MUL_W'(OUT_MIN)) begin
            w_res.sx = IN_W'(OUT_MIN); w_res.sat = 1'b1;
        end else begin
            w_res.sx = IN_W'(w_shx);
        end
        if (w_shy > MUL_W'(OUT_MAX)) begin
            w_res.sy = IN_W'(OUT_MAX); w_res.sat = 1'b1;
        end else if (w_shy < MUL_W'(OUT_MIN)) begin
            w_res.sy = IN_W'(OUT_MIN); w_res.sat = 1'b1;
        end else begin
            w_res.sy = IN_W'(w_shy);
        end
    end

    // result queue
    assign w_qpush = r_m1_vld && !w_qfull;
    assign w_qpop  = pop && !empty;
    assign empty   = (r_qcnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qwr  <= '0;
            r_qrd  <= '0;
            r_qcnt <= '0;
        end else begin
            if (w_qpush) r_qwr <= r_qwr + 1'b1;
            if (w_qpop)  r_qrd <= r_qrd + 1'b1;
            r_qcnt <= r_qcnt + (OUTQ_AW+1)'(w_qpush) - (OUTQ_AW+1)'(w_qpop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_qpush) r_q[r_qwr] <= w_res;
    end

    assign o_screen_x  = r_q[r_qrd].sx;
    assign o_screen_y  = r_q[r_qrd].sy;
    assign o_saturated = r_q[r_qrd].sat;

endmodule

@@ design/world_to_screen_projection.sv @@
// world-to-screen projection top level: config registers, front, queue, back
// throughput: one point per cycle while no stall holds it, through the fully pipelined 41-stage divider
// stalls: a full result queue holds the back part, a full middle queue the front
// reset: synchronous active low, clears queues and valids, config to reset values
// depends on wtsp_pkg, wtsp_front, wtsp_fifo, wtsp_back
module world_to_screen_projection import wtsp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_W-1:0]       i_cfg_data,
    input  logic                   push,
    output logic                   full,
    input  logic signed [IN_W-1:0] i_world_x,
    input  logic signed [IN_W-1:0] i_world_y,
    input  logic signed [IN_W-1:0] i_world_z,
    output logic                   empty,
    input  logic                   pop,
    output logic signed [IN_W-1:0] o_screen_x,
    output logic signed [IN_W-1:0] o_screen_y,
    output logic                   o_saturated
);

    t_rows   r_rows;
    t_view   r_view;
    logic    w_clip_vld, w_mid_pop;
    t_clip   w_clip_in, w_clip_out;
    t_q_stat w_mid;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows         <= '0;
            r_view.width   <= '0;
            r_view.height  <= '0;
            r_view.floor_v <= FLOOR_W'(66);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ROW_X_LO: begin
                    r_rows.row_x.cx <= i_cfg_data[31:0];
                    r_rows.row_x.cy <= i_cfg_data[63:32];
                end
                REG_ROW_X_HI: begin
                    r_rows.row_x.cz <= i_cfg_data[31:0];
                    r_rows.row_x.ct <= i_cfg_data[63:32];
                end
                REG_ROW_Y_LO: begin
                    r_rows.row_y.cx <= i_cfg_data[31:0];
                    r_rows.row_y.cy <= i_cfg_data[63:32];
                end
                REG_ROW_Y_HI: begin
                    r_rows.row_y.cz <= i_cfg_data[31:0];
                    r_rows.row_y.ct <= i_cfg_data[63:32];
                end
                REG_ROW_W_LO: begin
                    r_rows.row_w.cx <= i_cfg_data[31:0];
                    r_rows.row_w.cy <= i_cfg_data[63:32];
                end
                REG_ROW_W_HI: begin
                    r_rows.row_w.cz <= i_cfg_data[31:0];
                    r_rows.row_w.ct <= i_cfg_data[63:32];
                end
                REG_SCREEN: begin
                    r_view.width  <= i_cfg_data[31:16];
                    r_view.height <= i_cfg_data[15:0];
                end
                REG_FLOOR: begin
                    r_view.floor_v <= i_cfg_data[30:0];
                end
                default: ;
            endcase
        end
    end

    // front part
    wtsp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_world_x  (i_world_x),
        .i_world_y  (i_world_y),
        .i_world_z  (i_world_z),
        .i_rows     (r_rows),
        .i_mid_full (w_mid.full),
        .o_clip_vld (w_clip_vld),
        .o_clip     (w_clip_in)
    );

    // queue between the parts
    wtsp_fifo u_mid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_clip_vld),
        .i_data  (w_clip_in),
        .i_pop   (w_mid_pop),
        .o_data  (w_clip_out),
        .o_stat  (w_mid)
    );

    // back part
    wtsp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_view       (r_view),
        .i_clip       (w_clip_out),
        .i_clip_empty (w_mid.empty),
        .o_clip_pop   (w_mid_pop),
        .empty        (empty),
        .pop          (pop),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_saturated  (o_saturated)
    );

    // the front only stalls on a full middle queue
    a_full_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> w_mid.full)
        else $error("front stalled without a full middle queue");

    // a transfer out of the middle queue only takes a real entry
    a_mid_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> !w_mid.empty)
        else $error("middle queue popped while empty");

    // no result can be waiting right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

endmodule
